// ===== design/nph_pkg.sv =====
// ----------------------------------------------------------------------------
// nph_pkg
// Shared types, codes and constant tables of the image header parser.
// ----------------------------------------------------------------------------
package nph_pkg;

  parameter int unsigned DIM_BITS_DEF = 32;
  parameter int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [4:0] {
    PH_IDLE, PH_START, PH_TYPE, PH_YMAGIC, PH_PSEP_REQ, PH_PSEP, PH_PCMT,
    PH_PNUM, PH_FWS1, PH_FDIG0, PH_FNUM, PH_FSIGN, PH_FINT, PH_FFRAC,
    PH_YTAG, PH_YFIELD, PH_YDIG0, PH_YNUM, PH_YI, PH_YC, PH_YSKIP,
    PH_YFRAME, PH_YFLINE
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK, ST_MAGIC, ST_SYNTAX, ST_EARLY, ST_MAXVAL, ST_OVF, ST_Y4M
  } status_e;

  localparam logic [2:0] FMT_PBM = 3'd0;
  localparam logic [2:0] FMT_PGM = 3'd1;
  localparam logic [2:0] FMT_PPM = 3'd2;
  localparam logic [2:0] FMT_PFC = 3'd3;
  localparam logic [2:0] FMT_PFG = 3'd4;
  localparam logic [2:0] FMT_Y4M = 3'd5;

  localparam logic [1:0] CH_NONE = 2'd0;
  localparam logic [1:0] CH_444  = 2'd1;
  localparam logic [1:0] CH_422  = 2'd2;
  localparam logic [1:0] CH_420  = 2'd3;

  localparam logic [7:0] CH_LF = 8'h0A;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       is_ws;
    logic       is_lb;
    logic       is_digit;
    logic [3:0] digit;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  format;
    logic [31:0] width;
    logic [31:0] height;
    logic [5:0]  sample_bits;
    logic        gray;
    logic [1:0]  chroma_mode;
    logic        msb_first;
    logic        float_samples;
    logic [15:0] header_length;
  } res_t;

  function automatic logic [7:0] y4m_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0: c = "Y";
      4'd1: c = "U";
      4'd2: c = "V";
      4'd3: c = "4";
      4'd4: c = "M";
      4'd5: c = "P";
      4'd6: c = "E";
      4'd7: c = "G";
      4'd8: c = "2";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] frame_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0: c = "F";
      4'd1: c = "R";
      4'd2: c = "A";
      4'd3: c = "M";
      4'd4: c = "E";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== design/nph_if.sv =====
// ----------------------------------------------------------------------------
// nph_if
// Byte input channel and result output channel of the header parser.
// ----------------------------------------------------------------------------
interface nph_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;
  logic       last;
  modport source(output valid, data_byte, first, last, input ready);
  modport sink(input valid, data_byte, first, last, output ready);
endinterface

interface nph_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [2:0]  format;
  logic [31:0] width;
  logic [31:0] height;
  logic [5:0]  sample_bits;
  logic        gray;
  logic [1:0]  chroma_mode;
  logic        msb_first;
  logic        float_samples;
  logic [15:0] header_length;
  modport source(output valid, status, format, width, height, sample_bits, gray,
                 chroma_mode, msb_first, float_samples, header_length,
                 input ready);
  modport sink(input valid, status, format, width, height, sample_bits, gray,
               chroma_mode, msb_first, float_samples, header_length,
               output ready);
endinterface

// ===== design/nph_front.sv =====
// ----------------------------------------------------------------------------
// nph_front
// Accepts bytes, classifies them and queues them for the parser.
// ----------------------------------------------------------------------------
module nph_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  nph_in_if.sink          in_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output nph_pkg::item_t  q_item_o
);

  nph_pkg::item_t                     mem_q [nph_pkg::QDEPTH];
  logic [nph_pkg::QPTR_W-1:0]         wptr_q, rptr_q;
  logic [nph_pkg::QCNT_W-1:0]         cnt_q;
  nph_pkg::item_t                     cls;
  logic                               push, pop;

  always_comb begin
    cls.data     = in_i.data_byte;
    cls.first    = in_i.first;
    cls.last     = in_i.last;
    cls.is_lb    = (in_i.data_byte == 8'h0D) || (in_i.data_byte == 8'h0A);
    cls.is_ws    = cls.is_lb || (in_i.data_byte == 8'h20) || (in_i.data_byte == 8'h09);
    cls.is_digit = (in_i.data_byte >= 8'h30) && (in_i.data_byte <= 8'h39);
    cls.digit    = in_i.data_byte[3:0];
  end

  assign in_i.ready = (cnt_q != nph_pkg::QCNT_W'(nph_pkg::QDEPTH));
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rptr_q];
  assign push       = in_i.valid && in_i.ready;
  assign pop        = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == nph_pkg::QPTR_W'(nph_pkg::QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (pop) begin
        rptr_q <= (rptr_q == nph_pkg::QPTR_W'(nph_pkg::QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== design/nph_back.sv =====
// ----------------------------------------------------------------------------
// nph_back
// Header FSM and result register; one byte per cycle while no result is held.
// ----------------------------------------------------------------------------
module nph_back #(
  parameter int unsigned DIM_BITS = nph_pkg::DIM_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  nph_pkg::item_t  q_item_i,
  nph_out_if.source       out_o
);

  nph_pkg::phase_e       phase_q, phase_d;
  logic [DIM_BITS-1:0]   acc_q, acc_d, width_q, width_d, height_q, height_d;
  logic                  ovf_q, ovf_d, sneg_q, sneg_d, snz_q, snz_d;
  logic [2:0]            fmt_q, fmt_d;
  logic [5:0]            bits_q, bits_d;
  logic [1:0]            chroma_q, chroma_d, cch_q, cch_d;
  logic [3:0]            midx_q, midx_d;
  logic [15:0]           cnt_q, cnt_d;
  logic                  ovalid_q;
  nph_pkg::res_t         res_q, res_d;

  logic [DIM_BITS+3:0]   mac;
  logic                  mac_big, max_bad_q, max_bad_d;
  logic [15:0]           mv1;
  logic [5:0]            enc;
  logic [63:0]           w_ext, h_ext;
  logic                  take, done, do_sep, sep_req, do_tag;
  nph_pkg::status_e      st;
  nph_pkg::phase_e       ph;
  logic [7:0]            c;

  assign c         = q_item_i.data;
  assign q_ready_o = !ovalid_q || out_o.ready;
  assign take      = q_valid_i && q_ready_o;

  assign mac     = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (DIM_BITS + 4)'(q_item_i.digit);
  assign mac_big = (mac[DIM_BITS+3:DIM_BITS] != 4'd0);

  assign max_bad_q = ovf_q || (acc_q < DIM_BITS'(2)) || (acc_q > DIM_BITS'(65535));
  assign max_bad_d = ovf_d || (acc_d < DIM_BITS'(2)) || (acc_d > DIM_BITS'(65535));
  assign mv1       = acc_q[15:0] - 16'd1;

  always_comb begin
    enc = 6'd0;
    for (int i = 0; i < 16; i++) begin
      if (mv1[i]) enc = 6'(i + 1);
    end
  end

  assign w_ext = 64'(width_d);
  assign h_ext = 64'(height_d);

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    ovf_d    = ovf_q;
    fmt_d    = fmt_q;
    width_d  = width_q;
    height_d = height_q;
    bits_d   = bits_q;
    chroma_d = chroma_q;
    sneg_d   = sneg_q;
    snz_d    = snz_q;
    midx_d   = midx_q;
    cch_d    = cch_q;
    cnt_d    = cnt_q;
    done     = 1'b0;
    st       = nph_pkg::ST_OK;
    do_sep   = 1'b0;
    sep_req  = 1'b0;
    do_tag   = 1'b0;
    if (q_item_i.first) begin
      acc_d = '0; ovf_d = 1'b0; fmt_d = '0; width_d = '0; height_d = '0;
      bits_d = '0; chroma_d = '0; sneg_d = 1'b0; snz_d = 1'b0;
      midx_d = '0; cch_d = '0; cnt_d = '0;
      phase_d = nph_pkg::PH_START;
    end
    ph = phase_d;
    if (ph != nph_pkg::PH_IDLE) begin
      if (cnt_d != 16'hFFFF) cnt_d = cnt_d + 16'd1;
      unique case (ph)
        nph_pkg::PH_START: begin
          if (c == "P") phase_d = nph_pkg::PH_TYPE;
          else if (c == "Y") begin phase_d = nph_pkg::PH_YMAGIC; midx_d = 4'd1; end
          else begin done = 1'b1; st = nph_pkg::ST_MAGIC; end
        end
        nph_pkg::PH_TYPE: begin
          midx_d = 4'd0;
          if (c == "4" || c == "5" || c == "6") begin
            fmt_d = 3'(c - 8'h34); phase_d = nph_pkg::PH_PSEP_REQ;
          end else if (c == "F" || c == "f") begin
            fmt_d = (c == "F") ? nph_pkg::FMT_PFC : nph_pkg::FMT_PFG;
            phase_d = nph_pkg::PH_FWS1;
          end else begin done = 1'b1; st = nph_pkg::ST_MAGIC; end
        end
        nph_pkg::PH_YMAGIC: begin
          if (midx_q > 4'd8 || c != nph_pkg::y4m_char(midx_q)) begin
            done = 1'b1; st = nph_pkg::ST_MAGIC;
          end else begin
            midx_d = midx_q + 4'd1;
            if (midx_d == 4'd9) begin
              fmt_d = nph_pkg::FMT_Y4M; chroma_d = nph_pkg::CH_420;
              width_d = '0; height_d = '0; phase_d = nph_pkg::PH_YTAG;
            end
          end
        end
        nph_pkg::PH_PSEP_REQ: begin do_sep = 1'b1; sep_req = 1'b1; end
        nph_pkg::PH_PSEP: do_sep = 1'b1;
        nph_pkg::PH_PCMT: if (q_item_i.is_lb) phase_d = nph_pkg::PH_PSEP;
        nph_pkg::PH_PNUM: begin
          if (q_item_i.is_digit) begin
            if (!ovf_q) begin
              if (mac_big) ovf_d = 1'b1;
              else acc_d = mac[DIM_BITS-1:0];
            end
          end else if (midx_q == 4'd0) begin
            if (ovf_q) begin done = 1'b1; st = nph_pkg::ST_OVF; end
            else begin width_d = acc_q; midx_d = 4'd1; do_sep = 1'b1; sep_req = 1'b1; end
          end else if (midx_q == 4'd1) begin
            if (ovf_q) begin done = 1'b1; st = nph_pkg::ST_OVF; end
            else begin
              height_d = acc_q;
              if (fmt_q == nph_pkg::FMT_PBM) begin
                done = 1'b1;
                st = q_item_i.is_ws ? nph_pkg::ST_OK : nph_pkg::ST_SYNTAX;
              end else begin midx_d = 4'd2; do_sep = 1'b1; sep_req = 1'b1; end
            end
          end else begin
            done = 1'b1;
            if (max_bad_q) st = nph_pkg::ST_MAXVAL;
            else begin
              bits_d = enc;
              st = q_item_i.is_ws ? nph_pkg::ST_OK : nph_pkg::ST_SYNTAX;
            end
          end
        end
        nph_pkg::PH_FWS1: begin
          if (!q_item_i.is_ws) begin done = 1'b1; st = nph_pkg::ST_SYNTAX; end
          else begin phase_d = nph_pkg::PH_FDIG0; midx_d = 4'd0; end
        end
        nph_pkg::PH_FDIG0, nph_pkg::PH_YDIG0: begin
          if (!q_item_i.is_digit) begin done = 1'b1; st = nph_pkg::ST_SYNTAX; end
          else begin
            acc_d = DIM_BITS'(q_item_i.digit); ovf_d = 1'b0;
            phase_d = (ph == nph_pkg::PH_FDIG0) ? nph_pkg::PH_FNUM : nph_pkg::PH_YNUM;
          end
        end
        nph_pkg::PH_FNUM: begin
          if (q_item_i.is_digit) begin
            if (!ovf_q) begin
              if (mac_big) ovf_d = 1'b1;
              else acc_d = mac[DIM_BITS-1:0];
            end
          end else if (ovf_q) begin done = 1'b1; st = nph_pkg::ST_OVF; end
          else if (midx_q == 4'd0) begin
            width_d = acc_q;
            if (c != " " && c != nph_pkg::CH_LF) begin done = 1'b1; st = nph_pkg::ST_SYNTAX; end
            else begin midx_d = 4'd1; phase_d = nph_pkg::PH_FDIG0; end
          end else begin
            height_d = acc_q;
            if (!q_item_i.is_ws) begin done = 1'b1; st = nph_pkg::ST_SYNTAX; end
            else phase_d = nph_pkg::PH_FSIGN;
          end
        end
        nph_pkg::PH_FSIGN: begin
          if (c == "-") begin sneg_d = 1'b1; phase_d = nph_pkg::PH_FINT; end
          else if (q_item_i.is_digit) begin
            if (c != "0") snz_d = 1'b1;
            phase_d = nph_pkg::PH_FINT;
          end else if (c == "+") phase_d = nph_pkg::PH_FINT;
          else begin done = 1'b1; st = nph_pkg::ST_SYNTAX; end
        end
        nph_pkg::PH_FINT, nph_pkg::PH_FFRAC: begin
          if (q_item_i.is_digit) begin
            if (c != "0") snz_d = 1'b1;
          end else if (c == "." && ph == nph_pkg::PH_FINT) phase_d = nph_pkg::PH_FFRAC;
          else begin
            done = 1'b1;
            st = q_item_i.is_ws ? nph_pkg::ST_OK : nph_pkg::ST_SYNTAX;
          end
        end
        nph_pkg::PH_YTAG: do_tag = 1'b1;
        nph_pkg::PH_YFIELD: begin
          if (c == "W" || c == "H") begin
            midx_d = (c == "H") ? 4'd1 : 4'd0; phase_d = nph_pkg::PH_YDIG0;
          end else if (c == "I") phase_d = nph_pkg::PH_YI;
          else if (c == "C") begin cch_d = 2'd0; phase_d = nph_pkg::PH_YC; end
          else if (c == "F" || c == "A" || c == "X") phase_d = nph_pkg::PH_YSKIP;
          else begin done = 1'b1; st = nph_pkg::ST_SYNTAX; end
        end
        nph_pkg::PH_YNUM: begin
          if (q_item_i.is_digit) begin
            if (!ovf_q) begin
              if (mac_big) ovf_d = 1'b1;
              else acc_d = mac[DIM_BITS-1:0];
            end
          end else if (ovf_q) begin done = 1'b1; st = nph_pkg::ST_OVF; end
          else begin
            if (midx_q == 4'd0) width_d = acc_q;
            else height_d = acc_q;
            do_tag = 1'b1;
          end
        end
        nph_pkg::PH_YI: begin
          if (c != "p") begin done = 1'b1; st = nph_pkg::ST_Y4M; end
          else phase_d = nph_pkg::PH_YTAG;
        end
        nph_pkg::PH_YC: begin
          unique case (cch_q)
            2'd0: begin
              if (c != "4") begin done = 1'b1; st = nph_pkg::ST_Y4M; end
              else cch_d = 2'd1;
            end
            2'd1: begin
              if (c == "4") cch_d = 2'd2;
              else if (c == "2") cch_d = 2'd3;
              else begin done = 1'b1; st = nph_pkg::ST_Y4M; end
            end
            2'd2: begin
              if (c != "4") begin done = 1'b1; st = nph_pkg::ST_Y4M; end
              else begin chroma_d = nph_pkg::CH_444; phase_d = nph_pkg::PH_YSKIP; end
            end
            default: begin
              if (c == "2") begin chroma_d = nph_pkg::CH_422; phase_d = nph_pkg::PH_YSKIP; end
              else if (c == "0") begin
                chroma_d = nph_pkg::CH_420; phase_d = nph_pkg::PH_YSKIP;
              end else begin done = 1'b1; st = nph_pkg::ST_Y4M; end
            end
          endcase
        end
        nph_pkg::PH_YSKIP: if (c == " " || c == nph_pkg::CH_LF) do_tag = 1'b1;
        nph_pkg::PH_YFRAME: begin
          if (midx_q > 4'd4 || c != nph_pkg::frame_char(midx_q)) begin
            done = 1'b1; st = nph_pkg::ST_SYNTAX;
          end else begin
            midx_d = midx_q + 4'd1;
            if (midx_d == 4'd5) phase_d = nph_pkg::PH_YFLINE;
          end
        end
        nph_pkg::PH_YFLINE: if (c == nph_pkg::CH_LF) done = 1'b1;
        default: ;
      endcase
      if (do_sep) begin
        if (q_item_i.is_ws) phase_d = nph_pkg::PH_PSEP;
        else if (c == "#") phase_d = nph_pkg::PH_PCMT;
        else if (q_item_i.is_digit && !sep_req) begin
          acc_d = DIM_BITS'(q_item_i.digit); ovf_d = 1'b0; phase_d = nph_pkg::PH_PNUM;
        end else begin done = 1'b1; st = nph_pkg::ST_SYNTAX; end
      end
      if (do_tag) begin
        if (c == nph_pkg::CH_LF) begin phase_d = nph_pkg::PH_YFRAME; midx_d = 4'd0; end
        else if (c == " ") phase_d = nph_pkg::PH_YFIELD;
        else phase_d = nph_pkg::PH_YTAG;
      end
      if (!done && q_item_i.last) begin
        done = 1'b1;
        if (phase_d == nph_pkg::PH_PNUM) begin
          if (midx_d >= 4'd2) st = max_bad_d ? nph_pkg::ST_MAXVAL : nph_pkg::ST_EARLY;
          else st = ovf_d ? nph_pkg::ST_OVF : nph_pkg::ST_EARLY;
        end else if ((phase_d == nph_pkg::PH_FNUM || phase_d == nph_pkg::PH_YNUM) && ovf_d) begin
          st = nph_pkg::ST_OVF;
        end else st = nph_pkg::ST_EARLY;
      end
      if (done) phase_d = nph_pkg::PH_IDLE;
    end
  end

  always_comb begin
    res_d               = '0;
    res_d.status        = st;
    res_d.format        = fmt_d;
    res_d.header_length = cnt_d;
    if (st == nph_pkg::ST_OK) begin
      res_d.width  = w_ext[31:0];
      res_d.height = h_ext[31:0];
      if (fmt_d == nph_pkg::FMT_PBM) res_d.sample_bits = 6'd1;
      else if (fmt_d <= nph_pkg::FMT_PPM) res_d.sample_bits = bits_d;
      else if (fmt_d <= nph_pkg::FMT_PFG) res_d.sample_bits = 6'd32;
      else res_d.sample_bits = 6'd8;
      res_d.gray = (fmt_d == nph_pkg::FMT_PBM) || (fmt_d == nph_pkg::FMT_PGM) ||
                   (fmt_d == nph_pkg::FMT_PFG);
      res_d.chroma_mode = (fmt_d == nph_pkg::FMT_Y4M) ? chroma_d : nph_pkg::CH_NONE;
      if (fmt_d <= nph_pkg::FMT_PPM) res_d.msb_first = 1'b1;
      else if (fmt_d <= nph_pkg::FMT_PFG) res_d.msb_first = !(sneg_d && snz_d);
      else res_d.msb_first = 1'b0;
      res_d.float_samples = (fmt_d == nph_pkg::FMT_PFC) || (fmt_d == nph_pkg::FMT_PFG);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && done) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= nph_pkg::PH_IDLE;
      acc_q    <= '0;
      ovf_q    <= 1'b0;
      fmt_q    <= '0;
      width_q  <= '0;
      height_q <= '0;
      bits_q   <= '0;
      chroma_q <= '0;
      sneg_q   <= 1'b0;
      snz_q    <= 1'b0;
      midx_q   <= '0;
      cch_q    <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q  <= phase_d;
        acc_q    <= acc_d;
        ovf_q    <= ovf_d;
        fmt_q    <= fmt_d;
        width_q  <= width_d;
        height_q <= height_d;
        bits_q   <= bits_d;
        chroma_q <= chroma_d;
        sneg_q   <= sneg_d;
        snz_q    <= snz_d;
        midx_q   <= midx_d;
        cch_q    <= cch_d;
        cnt_q    <= cnt_d;
      end
      if (take && done) ovalid_q <= 1'b1;
      else if (out_o.ready) ovalid_q <= 1'b0;
    end
  end

  assign out_o.valid         = ovalid_q;
  assign out_o.status        = res_q.status;
  assign out_o.format        = res_q.format;
  assign out_o.width         = res_q.width;
  assign out_o.height        = res_q.height;
  assign out_o.sample_bits   = res_q.sample_bits;
  assign out_o.gray          = res_q.gray;
  assign out_o.chroma_mode   = res_q.chroma_mode;
  assign out_o.msb_first     = res_q.msb_first;
  assign out_o.float_samples = res_q.float_samples;
  assign out_o.header_length = res_q.header_length;

endmodule

// ===== design/netpbm_pfm_y4m_header_parser.sv =====
// ----------------------------------------------------------------------------
// netpbm_pfm_y4m_header_parser
// PBM/PGM/PPM, PFM and YUV4MPEG2 header recognizer, one byte per transaction.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the result register is free or being read, set by the single-step parser FSM.
// Path: the byte that ends the header passes through the 2-entry byte queue and
//   then the result register; a result held in that register stalls the queue.
// Reset: asynchronous; queue empty, parser idle until a byte with first set.
module netpbm_pfm_y4m_header_parser #(
  parameter int unsigned DIM_BITS = nph_pkg::DIM_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nph_in_if.sink     in_i,
  nph_out_if.source  out_o
);

  logic            q_valid, q_ready;
  nph_pkg::item_t  q_item;

  nph_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_item_o  (q_item)
  );

  nph_back #(.DIM_BITS(DIM_BITS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_ready_o (q_ready),
    .q_item_i  (q_item),
    .out_o     (out_o)
  );

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status != 3'(nph_pkg::ST_OK)) |->
      (out_o.width == 32'd0) && (out_o.height == 32'd0) && (out_o.sample_bits == 6'd0))
    else $error("error result carries image fields");

  a_pbm_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.status == 3'(nph_pkg::ST_OK)) &&
      (out_o.format == nph_pkg::FMT_PBM) |->
      (out_o.sample_bits == 6'd1) && out_o.gray && out_o.msb_first)
    else $error("pbm result fields inconsistent");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_valid && q_ready |-> !out_o.valid || out_o.ready)
    else $error("byte consumed while result stalled");

endmodule

// ===== sim/netpbm_pfm_y4m_header_parser_tb.sv =====
// ----------------------------------------------------------------------------
// netpbm_pfm_y4m_header_parser_tb
// Feeds directed and random PNM, PFM and Y4M headers byte by byte, predicts
// each header result with a local parser model and compares every result.
// ----------------------------------------------------------------------------
module netpbm_pfm_y4m_header_parser_tb;

  localparam int          MORE      = -1;
  localparam logic [63:0] DIM_MAX   = 64'hFFFF_FFFF;
  localparam int          RAND_BYTES = 450;
  localparam int          HOLD_CYCLES = 300;

  typedef struct {
    logic [7:0]       data;
    bit               first;
    bit               last;
    bit               typed;
    nph_pkg::status_e typed_status;
  } byte_stim_t;

  logic clk;
  logic rst_n;

  nph_in_if  in_if();
  nph_out_if out_if();

  netpbm_pfm_y4m_header_parser dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // parser model state
  nph_pkg::phase_e ph = nph_pkg::PH_IDLE;
  logic [63:0] acc;
  bit          acc_ovf;
  logic [2:0]  fmt;
  logic [63:0] wid, hgt;
  logic [5:0]  bits;
  logic [1:0]  chroma;
  bit          scale_neg, scale_nz;
  logic [3:0]  idx;
  logic [1:0]  cchars;
  logic [15:0] nbytes;

  string Y4M_WORD   = "YUV4MPEG2";
  string FRAME_WORD = "FRAME";

  byte_stim_t       stim_q[$];
  byte unsigned     file_bytes[$];
  nph_pkg::res_t    pending_headers[$];
  int               n_directed;
  int               idle_mode;
  int               accepted = 0;
  int               errors = 0;
  bit               cur_typed;
  nph_pkg::status_e cur_typed_status;

  function automatic bit is_ws(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic bit is_lb(logic [7:0] c);
    return c == 8'h0D || c == 8'h0A;
  endfunction

  function automatic bit is_dig(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic void add_digit(logic [7:0] c);
    logic [63:0] d;
    d = 64'(c - "0");
    if (!acc_ovf) begin
      if (acc > (DIM_MAX - d) / 10) acc_ovf = 1;
      else acc = acc * 10 + d;
    end
  endfunction

  function automatic void start_digits(logic [7:0] c);
    acc = 0;
    acc_ovf = 0;
    add_digit(c);
  endfunction

  function automatic int maxval_chk();
    int b;
    b = 0;
    if (acc_ovf || acc < 2 || acc > 65535) return int'(nph_pkg::ST_MAXVAL);
    while ((64'd1 << b) < acc) b++;
    bits = 6'(b);
    return MORE;
  endfunction

  function automatic int pnm_sep(logic [7:0] c, bit required);
    if (is_ws(c)) begin
      ph = nph_pkg::PH_PSEP; return MORE;
    end
    if (c == "#") begin
      ph = nph_pkg::PH_PCMT; return MORE;
    end
    if (is_dig(c) && !required) begin
      start_digits(c); ph = nph_pkg::PH_PNUM; return MORE;
    end
    return int'(nph_pkg::ST_SYNTAX);
  endfunction

  function automatic int pnm_num_end(logic [7:0] c);
    int r;
    if (idx == 0) begin
      if (acc_ovf) return int'(nph_pkg::ST_OVF);
      wid = acc; idx = 1;
      return pnm_sep(c, 1);
    end
    if (idx == 1) begin
      if (acc_ovf) return int'(nph_pkg::ST_OVF);
      hgt = acc;
      if (fmt == nph_pkg::FMT_PBM)
        return is_ws(c) ? int'(nph_pkg::ST_OK) : int'(nph_pkg::ST_SYNTAX);
      idx = 2;
      return pnm_sep(c, 1);
    end
    r = maxval_chk();
    if (r >= 0) return r;
    return is_ws(c) ? int'(nph_pkg::ST_OK) : int'(nph_pkg::ST_SYNTAX);
  endfunction

  function automatic int y4m_tag(logic [7:0] c);
    if (c == nph_pkg::CH_LF) begin
      ph = nph_pkg::PH_YFRAME; idx = 0;
    end else if (c == " ") ph = nph_pkg::PH_YFIELD;
    else ph = nph_pkg::PH_YTAG;
    return MORE;
  endfunction

  function automatic int consume_byte(logic [7:0] c);
    case (ph)
      nph_pkg::PH_START: begin
        if (c == "P") begin
          ph = nph_pkg::PH_TYPE; return MORE;
        end
        if (c == "Y") begin
          ph = nph_pkg::PH_YMAGIC; idx = 1; return MORE;
        end
        return int'(nph_pkg::ST_MAGIC);
      end
      nph_pkg::PH_TYPE: begin
        idx = 0;
        if (c == "4" || c == "5" || c == "6") begin
          fmt = 3'(c - "4"); ph = nph_pkg::PH_PSEP_REQ; return MORE;
        end
        if (c == "F" || c == "f") begin
          fmt = (c == "F") ? nph_pkg::FMT_PFC : nph_pkg::FMT_PFG;
          ph = nph_pkg::PH_FWS1; return MORE;
        end
        return int'(nph_pkg::ST_MAGIC);
      end
      nph_pkg::PH_YMAGIC: begin
        if (idx > 8 || c != Y4M_WORD[idx]) return int'(nph_pkg::ST_MAGIC);
        idx++;
        if (idx == 9) begin
          fmt = nph_pkg::FMT_Y4M; chroma = nph_pkg::CH_420; wid = 0; hgt = 0;
          ph = nph_pkg::PH_YTAG;
        end
        return MORE;
      end
      nph_pkg::PH_PSEP_REQ: return pnm_sep(c, 1);
      nph_pkg::PH_PSEP: return pnm_sep(c, 0);
      nph_pkg::PH_PCMT: begin
        if (is_lb(c)) ph = nph_pkg::PH_PSEP;
        return MORE;
      end
      nph_pkg::PH_PNUM: begin
        if (is_dig(c)) begin
          add_digit(c); return MORE;
        end
        return pnm_num_end(c);
      end
      nph_pkg::PH_FWS1: begin
        if (!is_ws(c)) return int'(nph_pkg::ST_SYNTAX);
        ph = nph_pkg::PH_FDIG0; idx = 0; return MORE;
      end
      nph_pkg::PH_FDIG0, nph_pkg::PH_YDIG0: begin
        if (!is_dig(c)) return int'(nph_pkg::ST_SYNTAX);
        start_digits(c);
        ph = (ph == nph_pkg::PH_FDIG0) ? nph_pkg::PH_FNUM : nph_pkg::PH_YNUM;
        return MORE;
      end
      nph_pkg::PH_FNUM: begin
        if (is_dig(c)) begin
          add_digit(c); return MORE;
        end
        if (acc_ovf) return int'(nph_pkg::ST_OVF);
        if (idx == 0) begin
          wid = acc;
          if (c != " " && c != nph_pkg::CH_LF) return int'(nph_pkg::ST_SYNTAX);
          idx = 1; ph = nph_pkg::PH_FDIG0; return MORE;
        end
        hgt = acc;
        if (!is_ws(c)) return int'(nph_pkg::ST_SYNTAX);
        ph = nph_pkg::PH_FSIGN; return MORE;
      end
      nph_pkg::PH_FSIGN: begin
        if (c == "-") scale_neg = 1;
        else if (is_dig(c)) begin
          if (c != "0") scale_nz = 1;
        end else if (c != "+") return int'(nph_pkg::ST_SYNTAX);
        ph = nph_pkg::PH_FINT; return MORE;
      end
      nph_pkg::PH_FINT, nph_pkg::PH_FFRAC: begin
        if (is_dig(c)) begin
          if (c != "0") scale_nz = 1;
          return MORE;
        end
        if (c == "." && ph == nph_pkg::PH_FINT) begin
          ph = nph_pkg::PH_FFRAC; return MORE;
        end
        return is_ws(c) ? int'(nph_pkg::ST_OK) : int'(nph_pkg::ST_SYNTAX);
      end
      nph_pkg::PH_YTAG: return y4m_tag(c);
      nph_pkg::PH_YFIELD: begin
        if (c == "W" || c == "H") begin
          idx = (c == "H") ? 4'd1 : 4'd0; ph = nph_pkg::PH_YDIG0; return MORE;
        end
        if (c == "I") begin
          ph = nph_pkg::PH_YI; return MORE;
        end
        if (c == "C") begin
          cchars = 0; ph = nph_pkg::PH_YC; return MORE;
        end
        if (c == "F" || c == "A" || c == "X") begin
          ph = nph_pkg::PH_YSKIP; return MORE;
        end
        return int'(nph_pkg::ST_SYNTAX);
      end
      nph_pkg::PH_YNUM: begin
        if (is_dig(c)) begin
          add_digit(c); return MORE;
        end
        if (acc_ovf) return int'(nph_pkg::ST_OVF);
        if (idx == 0) wid = acc;
        else hgt = acc;
        return y4m_tag(c);
      end
      nph_pkg::PH_YI: begin
        if (c != "p") return int'(nph_pkg::ST_Y4M);
        ph = nph_pkg::PH_YTAG; return MORE;
      end
      nph_pkg::PH_YC: begin
        if (cchars == 0) begin
          if (c != "4") return int'(nph_pkg::ST_Y4M);
          cchars = 1; return MORE;
        end
        if (cchars == 1) begin
          if (c == "4") cchars = 2;
          else if (c == "2") cchars = 3;
          else return int'(nph_pkg::ST_Y4M);
          return MORE;
        end
        if (cchars == 2) begin
          if (c != "4") return int'(nph_pkg::ST_Y4M);
          chroma = nph_pkg::CH_444;
        end else if (c == "2") chroma = nph_pkg::CH_422;
        else if (c == "0") chroma = nph_pkg::CH_420;
        else return int'(nph_pkg::ST_Y4M);
        ph = nph_pkg::PH_YSKIP; return MORE;
      end
      nph_pkg::PH_YSKIP: begin
        if (c == " " || c == nph_pkg::CH_LF) return y4m_tag(c);
        return MORE;
      end
      nph_pkg::PH_YFRAME: begin
        if (idx > 4 || c != FRAME_WORD[idx]) return int'(nph_pkg::ST_SYNTAX);
        idx++;
        if (idx == 5) ph = nph_pkg::PH_YFLINE;
        return MORE;
      end
      nph_pkg::PH_YFLINE: return (c == nph_pkg::CH_LF) ? int'(nph_pkg::ST_OK) : MORE;
      default: return MORE;
    endcase
  endfunction

  function automatic int data_ended();
    if (ph == nph_pkg::PH_PNUM) begin
      if (idx >= 2)
        return (maxval_chk() >= 0) ? int'(nph_pkg::ST_MAXVAL) : int'(nph_pkg::ST_EARLY);
      return acc_ovf ? int'(nph_pkg::ST_OVF) : int'(nph_pkg::ST_EARLY);
    end
    if ((ph == nph_pkg::PH_FNUM || ph == nph_pkg::PH_YNUM) && acc_ovf)
      return int'(nph_pkg::ST_OVF);
    return int'(nph_pkg::ST_EARLY);
  endfunction

  function automatic void clear_header();
    acc = 0; acc_ovf = 0; fmt = nph_pkg::FMT_PBM; wid = 0; hgt = 0; bits = 0;
    chroma = nph_pkg::CH_NONE; scale_neg = 0; scale_nz = 0; idx = 0; cchars = 0;
    nbytes = 0;
  endfunction

  function automatic void parse_byte(input logic [7:0] c, input bit first,
                                     input bit last, output bit got,
                                     output nph_pkg::res_t r);
    int s;
    got = 0;
    r = '0;
    if (first) begin
      clear_header(); ph = nph_pkg::PH_START;
    end
    if (ph == nph_pkg::PH_IDLE) return;
    if (nbytes != 16'hFFFF) nbytes++;
    s = consume_byte(c);
    if (s < 0 && last) s = data_ended();
    if (s < 0) return;
    got = 1;
    r.status = nph_pkg::status_e'(s[2:0]);
    r.format = fmt;
    r.header_length = nbytes;
    if (r.status == nph_pkg::ST_OK) begin
      r.width = wid[31:0];
      r.height = hgt[31:0];
      r.sample_bits = (fmt == nph_pkg::FMT_PBM) ? 6'd1 : (fmt <= nph_pkg::FMT_PPM) ? bits :
                      (fmt <= nph_pkg::FMT_PFG) ? 6'd32 : 6'd8;
      r.gray = (fmt == nph_pkg::FMT_PBM || fmt == nph_pkg::FMT_PGM ||
                fmt == nph_pkg::FMT_PFG);
      r.chroma_mode = (fmt == nph_pkg::FMT_Y4M) ? chroma : nph_pkg::CH_NONE;
      r.msb_first = (fmt <= nph_pkg::FMT_PPM) ? 1'b1 :
                    (fmt <= nph_pkg::FMT_PFG) ? !(scale_neg && scale_nz) : 1'b0;
      r.float_samples = (fmt == nph_pkg::FMT_PFC || fmt == nph_pkg::FMT_PFG);
    end
    ph = nph_pkg::PH_IDLE;
  endfunction

  // stimulus construction
  function automatic void put_str(string s);
    foreach (s[i]) file_bytes.push_back(s[i]);
  endfunction

  function automatic void put_ws();
    case ($urandom_range(0, 3))
      0: file_bytes.push_back(8'h20);
      1: file_bytes.push_back(8'h09);
      2: file_bytes.push_back(8'h0D);
      default: file_bytes.push_back(8'h0A);
    endcase
  endfunction

  function automatic void put_gap();
    int n;
    n = $urandom_range(1, 3);
    repeat (n) begin
      if ($urandom_range(0, 5) == 0) begin
        put_str("#");
        repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom_range(32, 126)));
        file_bytes.push_back($urandom_range(0, 1) ? 8'h0A : 8'h0D);
      end else put_ws();
    end
  endfunction

  function automatic void put_num();
    case ($urandom_range(0, 9))
      0: repeat ($urandom_range(10, 13)) file_bytes.push_back(8'("0" + $urandom_range(0, 9)));
      1: put_str("4294967295");
      default: put_str($sformatf("%0d", $urandom_range(0, 2000)));
    endcase
  endfunction

  function automatic void put_maxval();
    case ($urandom_range(0, 7))
      0: put_str("1");
      1: put_str("0");
      2: put_str("65535");
      3: put_str("65536");
      4: put_str("2");
      default: put_str($sformatf("%0d", $urandom_range(2, 70000)));
    endcase
  endfunction

  function automatic void build_file();
    int kind;
    file_bytes.delete();
    kind = $urandom_range(0, 5);
    case (kind)
      0, 1, 2: begin
        put_str($sformatf("P%0d", kind + 4));
        put_gap(); put_num(); put_gap(); put_num();
        if (kind != 0) begin
          put_gap(); put_maxval();
        end
        put_ws();
      end
      3: begin
        put_str($urandom_range(0, 1) ? "PF" : "Pf");
        put_ws(); put_num();
        file_bytes.push_back($urandom_range(0, 1) ? 8'h20 : 8'h0A);
        put_num(); put_ws();
        case ($urandom_range(0, 2))
          0: put_str("-");
          1: put_str("+");
          default: ;
        endcase
        put_str($urandom_range(0, 2) == 0 ? "0" : $sformatf("%0d", $urandom_range(0, 99)));
        if ($urandom_range(0, 1)) begin
          put_str(".");
          put_str($urandom_range(0, 2) == 0 ? "00" : $sformatf("%0d", $urandom_range(0, 999)));
        end
        put_ws();
      end
      default: begin
        put_str("YUV4MPEG2");
        repeat ($urandom_range(0, 5)) begin
          put_str(" ");
          case ($urandom_range(0, 6))
            0: begin put_str("W"); put_num(); end
            1: begin put_str("H"); put_num(); end
            2: put_str($urandom_range(0, 5) == 0 ? "It" : "Ip");
            3: case ($urandom_range(0, 5))
                 0: put_str("C444");
                 1: put_str("C422");
                 2: put_str("C420jpeg");
                 3: put_str("C411");
                 4: put_str("C420paldv");
                 default: put_str("C420");
               endcase
            4: put_str("F30000:1001");
            5: put_str("A1:1");
            default: put_str("XYSCSS=420");
          endcase
        end
        put_str("\nFRAME");
        if ($urandom_range(0, 1)) put_str(" Ixyz");
        put_str("\n");
      end
    endcase
    if ($urandom_range(0, 6) == 0)
      file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0)
      file_bytes = file_bytes[0:$urandom_range(0, file_bytes.size() - 1)];
  endfunction

  function automatic void queue_file(bit typed, nph_pkg::status_e st, bit ends);
    byte_stim_t b;
    foreach (file_bytes[i]) begin
      b.data = file_bytes[i];
      b.first = (i == 0);
      b.last = ends && (i == file_bytes.size() - 1);
      b.typed = typed;
      b.typed_status = st;
      stim_q.push_back(b);
    end
  endfunction

  function automatic void directed_row(string s, bit typed, nph_pkg::status_e st);
    file_bytes.delete();
    put_str(s);
    queue_file(typed, st, 1);
  endfunction

  function automatic void build_stimulus();
    byte_stim_t b;
    int rnd;
    directed_row("P4 3 2\n", 1, nph_pkg::ST_OK);
    directed_row("P5\n#c\n 640 480 255\n", 1, nph_pkg::ST_OK);
    directed_row("P6 1 1 65535 ", 1, nph_pkg::ST_OK);
    directed_row("P5 2\t2\r2\n", 0, nph_pkg::ST_OK);
    directed_row("P5 1 1 1\n", 1, nph_pkg::ST_MAXVAL);
    directed_row("P5 1 1 65536\n", 1, nph_pkg::ST_MAXVAL);
    directed_row("P4 4294967295 1\n", 0, nph_pkg::ST_OK);
    directed_row("P4 4294967296 1\n", 1, nph_pkg::ST_OVF);
    directed_row("PF\n4 2\n-1.0\n", 0, nph_pkg::ST_OK);
    directed_row("Pf 3 3\n-0.0\n", 0, nph_pkg::ST_OK);
    directed_row("Pf 3 3\n+2.5\n", 0, nph_pkg::ST_OK);
    directed_row("Q", 1, nph_pkg::ST_MAGIC);
    directed_row("P7", 1, nph_pkg::ST_MAGIC);
    directed_row("YUV4MZ", 1, nph_pkg::ST_MAGIC);
    directed_row("P4x", 1, nph_pkg::ST_SYNTAX);
    directed_row("YUV4MPEG2 W320 H240 Ip C444 F30:1 A1:1 Xyz\nFRAME\n", 0, nph_pkg::ST_OK);
    directed_row("YUV4MPEG2 C422\nFRAME x\n", 0, nph_pkg::ST_OK);
    directed_row("YUV4MPEG2\nFRAME\n", 0, nph_pkg::ST_OK);
    directed_row("YUV4MPEG2 It\n", 1, nph_pkg::ST_Y4M);
    directed_row("YUV4MPEG2 C411\n", 1, nph_pkg::ST_Y4M);
    directed_row("YUV4MPEG2 Z\n", 1, nph_pkg::ST_SYNTAX);
    directed_row("YUV4MPEG2 W99999999999\n", 1, nph_pkg::ST_OVF);
    directed_row("P5 10", 1, nph_pkg::ST_EARLY);
    directed_row("P5 10 10 70000", 1, nph_pkg::ST_MAXVAL);
    n_directed = stim_q.size();
    rnd = 0;
    while (rnd < RAND_BYTES) begin
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          b.data = 8'($urandom_range(0, 255));
          b.first = 0;
          b.last = $urandom_range(0, 1);
          b.typed = 0;
          b.typed_status = nph_pkg::ST_OK;
          stim_q.push_back(b);
        end
      end
      build_file();
      rnd += file_bytes.size();
      queue_file(0, nph_pkg::ST_OK, $urandom_range(0, 7) != 0);
    end
  endfunction

  // input side: predict on every accepted transaction
  always @(posedge clk) begin
    bit            got;
    nph_pkg::res_t r;
    if (rst_n && in_if.valid && in_if.ready) begin
      parse_byte(in_if.data_byte, in_if.first, in_if.last, got, r);
      if (got) begin
        if (cur_typed) r.status = cur_typed_status;
        pending_headers.push_back(r);
      end
      accepted++;
    end
  end

  // output side
  always @(posedge clk) begin
    nph_pkg::res_t act, exp_r;
    if (rst_n && out_if.valid && out_if.ready) begin
      act.status = nph_pkg::status_e'(out_if.status);
      act.format = out_if.format;
      act.width = out_if.width;
      act.height = out_if.height;
      act.sample_bits = out_if.sample_bits;
      act.gray = out_if.gray;
      act.chroma_mode = out_if.chroma_mode;
      act.msb_first = out_if.msb_first;
      act.float_samples = out_if.float_samples;
      act.header_length = out_if.header_length;
      if (pending_headers.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: %p", act);
      end else begin
        exp_r = pending_headers.pop_front();
        if (act !== exp_r) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", exp_r, act);
        end
      end
    end
  end

  // receiver with one long hold-off
  int  hold_left = 0;
  bit  held = 0;
  always @(negedge clk) begin
    int pct;
    pct = (idle_mode == 0) ? 77 : (idle_mode == 1) ? 18 : 0;
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (!held && accepted >= 150) begin
      held = 1;
      hold_left = HOLD_CYCLES;
      out_if.ready <= 1'b0;
    end else out_if.ready <= ($urandom_range(0, 99) >= pct);
  end

  initial begin
    int pct;
    int n_rand;
    in_if.valid = 0;
    in_if.data_byte = 0;
    in_if.first = 0;
    in_if.last = 0;
    idle_mode = 0;
    cur_typed = 0;
    cur_typed_status = nph_pkg::ST_OK;
    build_stimulus();
    n_rand = stim_q.size() - n_directed;
    rst_n = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    foreach (stim_q[i]) begin
      if (i < n_directed + n_rand / 3) idle_mode = 0;
      else if (i < n_directed + 2 * n_rand / 3) idle_mode = 1;
      else idle_mode = 2;
      pct = (idle_mode == 0) ? 18 : (idle_mode == 1) ? 77 : 0;
      while ($urandom_range(0, 99) < pct) begin
        in_if.valid <= 1'b0;
        @(negedge clk);
      end
      in_if.valid <= 1'b1;
      in_if.data_byte <= stim_q[i].data;
      in_if.first <= stim_q[i].first;
      in_if.last <= stim_q[i].last;
      cur_typed = stim_q[i].typed;
      cur_typed_status = stim_q[i].typed_status;
      @(posedge clk);
      while (!in_if.ready) @(posedge clk);
      @(negedge clk);
    end
    in_if.valid <= 1'b0;
    while (pending_headers.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
design/nph_pkg.sv
design/nph_if.sv
design/nph_front.sv
design/nph_back.sv
design/netpbm_pfm_y4m_header_parser.sv
sim/netpbm_pfm_y4m_header_parser_tb.sv
